FILE: design/stfmt_pkg.sv
// ----------------------------------------------------------------------------
// stfmt_pkg
// Shared types and constants of the stopwatch time formatter.
// ----------------------------------------------------------------------------
package stfmt_pkg;

  // elapsed-time queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned MS_W   = 32;
  localparam int unsigned CHAR_W = 6;
  localparam int unsigned POS_W  = 4;

  // display character codes
  localparam logic [CHAR_W-1:0] CH_SPACE  = 6'd32;
  localparam logic [CHAR_W-1:0] CH_PERIOD = 6'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 6'd48;
  localparam logic [CHAR_W-1:0] CH_COLON  = 6'd58;

  // display positions, leftmost first
  localparam logic [POS_W-1:0] POS_H3    = 4'd0;
  localparam logic [POS_W-1:0] POS_H2    = 4'd1;
  localparam logic [POS_W-1:0] POS_H1    = 4'd2;
  localparam logic [POS_W-1:0] POS_H0    = 4'd3;
  localparam logic [POS_W-1:0] POS_HCOL  = 4'd4;
  localparam logic [POS_W-1:0] POS_MT    = 4'd5;
  localparam logic [POS_W-1:0] POS_MU    = 4'd6;
  localparam logic [POS_W-1:0] POS_MCOL  = 4'd7;
  localparam logic [POS_W-1:0] POS_ST    = 4'd8;
  localparam logic [POS_W-1:0] POS_SU    = 4'd9;
  localparam logic [POS_W-1:0] POS_DOT   = 4'd10;
  localparam logic [POS_W-1:0] POS_MSH   = 4'd11;
  localparam logic [POS_W-1:0] POS_MST   = 4'd12;
  localparam logic [POS_W-1:0] POS_MSU   = 4'd13;
  localparam logic [POS_W-1:0] POS_LAST  = POS_MSU;

  // decimal digits of one elapsed time, hd0 is the thousands-of-hours digit
  typedef struct packed {
    logic       hrs_nz;
    logic [3:0] hd0;
    logic [3:0] hd1;
    logic [3:0] hd2;
    logic [3:0] hd3;
    logic [3:0] min_t;
    logic [3:0] min_u;
    logic [3:0] sec_t;
    logic [3:0] sec_u;
    logic [3:0] ms_h;
    logic [3:0] ms_t;
    logic [3:0] ms_u;
  } digits_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    digit_char = CH_ZERO + {2'b00, d};
  endfunction

endpackage

FILE: design/stfmt_front.sv
// ----------------------------------------------------------------------------
// stfmt_front
// Intake stage: takes a timestamp pair and registers the elapsed time.
// ----------------------------------------------------------------------------
module stfmt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [stfmt_pkg::MS_W-1:0]  start_ms,
  input  logic [stfmt_pkg::MS_W-1:0]  end_ms,
  output logic                        el_valid,
  input  logic                        el_ready,
  output logic [stfmt_pkg::MS_W-1:0]  el_ms
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [stfmt_pkg::MS_W-1:0] elapsed_r;

  assign in_ready = !valid_r || el_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // wraps modulo 2^32 like a free-running counter
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      elapsed_r <= end_ms - start_ms;
    end
  end

  assign el_valid = valid_r;
  assign el_ms    = elapsed_r;

endmodule

FILE: design/stfmt_queue.sv
// ----------------------------------------------------------------------------
// stfmt_queue
// Short first-in first-out queue of elapsed times between front and back.
// ----------------------------------------------------------------------------
module stfmt_queue #(
  parameter int unsigned DEPTH = stfmt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_valid,
  output logic                        wr_ready,
  input  logic [stfmt_pkg::MS_W-1:0]  wr_data,
  output logic                        rd_valid,
  input  logic                        rd_ready,
  output logic [stfmt_pkg::MS_W-1:0]  rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [stfmt_pkg::MS_W-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       push, pop;

  assign wr_ready = (count_r != CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: design/stfmt_conv.sv
// ----------------------------------------------------------------------------
// stfmt_conv
// Five-stage pipeline splitting elapsed milliseconds into decimal digits.
// ----------------------------------------------------------------------------
module stfmt_conv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        el_valid,
  output logic                        el_ready,
  input  logic [stfmt_pkg::MS_W-1:0]  el_ms,
  output logic                        dig_valid,
  input  logic                        dig_ready,
  output stfmt_pkg::digits_t          dig
);

  // reciprocal constants, exact over the value ranges seen here
  localparam logic [28:0] DIV1000_K = 29'd274877907;  // shift 38
  localparam logic [22:0] DIV60_K   = 23'd4473925;    // shift 28
  localparam logic [12:0] DIV10_K   = 13'd6554;       // shift 16
  localparam logic [10:0] DIV100_K  = 11'd1311;       // shift 17
  localparam logic [10:0] DIV1K_K   = 11'd1049;       // shift 20
  localparam logic [7:0]  DIV10S_K  = 8'd205;         // shift 11, six-bit values

  logic [4:0] v_r, v_nxt;
  logic       adv;

  // stage 1
  logic [60:0] p1_r;
  logic [31:0] x1_r;
  // stage 2
  logic [44:0] p2_r;
  logic [22:0] q1_r;
  logic [9:0]  ms2_r;
  // stage 3
  logic [38:0] p3_r;
  logic [16:0] q2_r;
  logic [9:0]  ms3_r;
  logic [5:0]  sec3_r;
  // stage 4
  logic [10:0] hrs4_r;
  logic [6:0]  ha4_r;
  logic [4:0]  hb4_r;
  logic [1:0]  hc4_r;
  logic [9:0]  ms4_r;
  logic [6:0]  msa4_r;
  logic [3:0]  msh4_r;
  logic [5:0]  sec4_r;
  logic [2:0]  sect4_r;
  logic [5:0]  min4_r;
  // stage 5
  stfmt_pkg::digits_t dig_r, dig_nxt;

  // combinational helpers
  logic [22:0] q1;
  logic [16:0] q2;
  logic [10:0] hrs;
  logic [23:0] ha_p;
  logic [21:0] hb_p;
  logic [21:0] hc_p;
  logic [20:0] msh_p;
  logic [22:0] msa_p;
  logic [13:0] sec_p;
  logic [13:0] min_p;
  logic [2:0]  min_t;

  assign adv      = !v_r[4] || dig_ready;
  assign el_ready = adv;

  always_comb begin
    v_nxt = v_r;
    if (adv) begin
      v_nxt = {v_r[3:0], el_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign q1    = p1_r[60:38];
  assign q2    = p2_r[44:28];
  assign hrs   = p3_r[38:28];
  assign ha_p  = 24'(hrs) * 24'(DIV10_K);
  assign hb_p  = 22'(hrs) * 22'(DIV100_K);
  assign hc_p  = 22'(hrs) * 22'(DIV1K_K);
  assign msh_p = 21'(ms3_r) * 21'(DIV100_K);
  assign msa_p = 23'(ms3_r) * 23'(DIV10_K);
  assign sec_p = 14'(sec3_r) * 14'(DIV10S_K);
  assign min_p = 14'(min4_r) * 14'(DIV10S_K);
  assign min_t = min_p[13:11];

  // last stage: remainders by ten give the digits
  always_comb begin
    dig_nxt.hrs_nz = (hrs4_r != '0);
    dig_nxt.hd0    = {2'b00, hc4_r};
    dig_nxt.hd1    = hb4_r[3:0] - 4'({2'b00, hc4_r} * 4'd10);
    dig_nxt.hd2    = ha4_r[3:0] - 4'(hb4_r[3:0] * 4'd10);
    dig_nxt.hd3    = hrs4_r[3:0] - 4'(ha4_r[3:0] * 4'd10);
    dig_nxt.min_t  = {1'b0, min_t};
    dig_nxt.min_u  = min4_r[3:0] - 4'({1'b0, min_t} * 4'd10);
    dig_nxt.sec_t  = {1'b0, sect4_r};
    dig_nxt.sec_u  = sec4_r[3:0] - 4'({1'b0, sect4_r} * 4'd10);
    dig_nxt.ms_h   = msh4_r;
    dig_nxt.ms_t   = msa4_r[3:0] - 4'(msh4_r * 4'd10);
    dig_nxt.ms_u   = ms4_r[3:0] - 4'(msa4_r[3:0] * 4'd10);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // seconds = elapsed / 1000
      p1_r    <= 61'(el_ms) * 61'(DIV1000_K);
      x1_r    <= el_ms;
      // minutes = seconds / 60, milliseconds = remainder
      p2_r    <= 45'(q1) * 45'(DIV60_K);
      q1_r    <= q1;
      ms2_r   <= x1_r[9:0] - 10'(q1[9:0] * 10'd1000);
      // hours = minutes / 60, seconds = remainder
      p3_r    <= 39'(q2) * 39'(DIV60_K);
      q2_r    <= q2;
      ms3_r   <= ms2_r;
      sec3_r  <= q1_r[5:0] - 6'(q2[5:0] * 6'd60);
      // digit quotients
      hrs4_r  <= hrs;
      ha4_r   <= ha_p[22:16];
      hb4_r   <= hb_p[21:17];
      hc4_r   <= hc_p[21:20];
      ms4_r   <= ms3_r;
      msa4_r  <= msa_p[22:16];
      msh4_r  <= msh_p[20:17];
      sec4_r  <= sec3_r;
      sect4_r <= sec_p[13:11];
      min4_r  <= q2_r[5:0] - 6'(hrs[5:0] * 6'd60);
      dig_r   <= dig_nxt;
    end
  end

  // stage 4 quotients all come from stage 3 values, hours included
  assign dig_valid = v_r[4];
  assign dig       = dig_r;

endmodule

FILE: design/stfmt_emit.sv
// ----------------------------------------------------------------------------
// stfmt_emit
// Character sequencer: sends the fourteen display characters of one time.
// ----------------------------------------------------------------------------
module stfmt_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               dig_valid,
  output logic                               dig_ready,
  input  stfmt_pkg::digits_t                 dig,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [stfmt_pkg::CHAR_W-1:0]       char_code,
  output logic [stfmt_pkg::POS_W-1:0]        position,
  output logic                               last
);

  stfmt_pkg::digits_t               rec_r;
  logic                             have_r, have_nxt;
  logic [stfmt_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic                             oval_r, oval_nxt;
  logic [stfmt_pkg::CHAR_W-1:0]     char_r;
  logic [stfmt_pkg::POS_W-1:0]      opos_r;
  logic                             olast_r;
  logic [stfmt_pkg::CHAR_W-1:0]     ch;
  logic                             send, at_last, load;

  assign send      = have_r && (!oval_r || out_ready);
  assign at_last   = (pos_r == stfmt_pkg::POS_LAST);
  assign dig_ready = !have_r || (send && at_last);
  assign load      = dig_valid && dig_ready;

  always_comb begin
    ch = stfmt_pkg::CH_SPACE;
    case (pos_r)
      stfmt_pkg::POS_H3: begin
        if (rec_r.hrs_nz && rec_r.hd0 != '0) ch = stfmt_pkg::digit_char(rec_r.hd0);
      end
      stfmt_pkg::POS_H2: begin
        if (rec_r.hrs_nz && (rec_r.hd0 != '0 || rec_r.hd1 != '0)) begin
          ch = stfmt_pkg::digit_char(rec_r.hd1);
        end
      end
      stfmt_pkg::POS_H1: begin
        if (rec_r.hrs_nz && (rec_r.hd0 != '0 || rec_r.hd1 != '0 || rec_r.hd2 != '0)) begin
          ch = stfmt_pkg::digit_char(rec_r.hd2);
        end
      end
      stfmt_pkg::POS_H0: begin
        if (rec_r.hrs_nz) ch = stfmt_pkg::digit_char(rec_r.hd3);
      end
      stfmt_pkg::POS_HCOL: begin
        if (rec_r.hrs_nz) ch = stfmt_pkg::CH_COLON;
      end
      stfmt_pkg::POS_MT: begin
        if (rec_r.hrs_nz || rec_r.min_t != '0) ch = stfmt_pkg::digit_char(rec_r.min_t);
      end
      stfmt_pkg::POS_MU:  ch = stfmt_pkg::digit_char(rec_r.min_u);
      stfmt_pkg::POS_MCOL: begin
        // blinks off in the second half of each second
        if (rec_r.ms_h <= 4'd4) ch = stfmt_pkg::CH_COLON;
      end
      stfmt_pkg::POS_ST:  ch = stfmt_pkg::digit_char(rec_r.sec_t);
      stfmt_pkg::POS_SU:  ch = stfmt_pkg::digit_char(rec_r.sec_u);
      stfmt_pkg::POS_DOT: ch = stfmt_pkg::CH_PERIOD;
      stfmt_pkg::POS_MSH: ch = stfmt_pkg::digit_char(rec_r.ms_h);
      stfmt_pkg::POS_MST: ch = stfmt_pkg::digit_char(rec_r.ms_t);
      stfmt_pkg::POS_MSU: ch = stfmt_pkg::digit_char(rec_r.ms_u);
      default:            ch = stfmt_pkg::CH_SPACE;
    endcase
  end

  always_comb begin
    have_nxt = have_r;
    pos_nxt  = pos_r;
    oval_nxt = oval_r;
    if (out_ready) begin
      oval_nxt = 1'b0;
    end
    if (send) begin
      oval_nxt = 1'b1;
      pos_nxt  = pos_r + 1'b1;
      if (at_last) begin
        have_nxt = 1'b0;
      end
    end
    if (load) begin
      have_nxt = 1'b1;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      pos_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
      pos_r  <= pos_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= dig;
    end
    if (send) begin
      char_r  <= ch;
      opos_r  <= pos_r;
      olast_r <= at_last;
    end
  end

  assign out_valid = oval_r;
  assign char_code = char_r;
  assign position  = opos_r;
  assign last      = olast_r;

endmodule

FILE: design/stopwatch_time_formatter_core.sv
// ----------------------------------------------------------------------------
// stopwatch_time_formatter_core
// Turns a start/end millisecond timestamp pair into the fourteen characters
// of an elapsed-time display, 'HHHH:MM:SS.mmm', one character per transaction.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit first)          | tuser | tlast
//  --------+-----------+--------------------------------+-------+----------------
//  in_     | slave     | start_ms[31:0], end_ms[63:32]  | -     | -
//  out_    | master    | char_code[5:0], position[9:6]  | -     | last character
//
//  one input transaction yields fourteen output transactions, one per cycle
//  while out_tready is high; sustained input rate is set by the character sequencer,
//  which loads the next time as it sends the last character of the current one
//  synchronous active-low reset clears all valid flags, counters and pointers
//  front and back stall independently; the queue and output register absorb
//  back-pressure on out_ without dropping or repeating characters
//
module stopwatch_time_formatter_core #(
  parameter int unsigned QUEUE_DEPTH = stfmt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // timestamp pair in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_ms[31:0], end_ms[63:32]
  // display characters out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // char_code[5:0], position[9:6], zero pad
  output logic        out_tlast
);

  // front to queue
  logic                              fe_valid;
  logic                              fe_ready;
  logic [stfmt_pkg::MS_W-1:0]        fe_ms;
  // queue to converter
  logic                              q_valid;
  logic                              q_ready;
  logic [stfmt_pkg::MS_W-1:0]        q_ms;
  // converter to character sequencer
  logic                              dig_valid;
  logic                              dig_ready;
  stfmt_pkg::digits_t                dig;
  // character fields
  logic [stfmt_pkg::CHAR_W-1:0]      char_code;
  logic [stfmt_pkg::POS_W-1:0]       position;

  // front: elapsed = end - start, modulo 2^32
  stfmt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .start_ms (in_tdata[31:0]),
    .end_ms   (in_tdata[63:32]),
    .el_valid (fe_valid),
    .el_ready (fe_ready),
    .el_ms    (fe_ms)
  );

  // decouples intake from the character loop
  stfmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_ms),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_ms)
  );

  // back, part one: split into hours, minutes, seconds, ms and their digits
  stfmt_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .el_valid  (q_valid),
    .el_ready  (q_ready),
    .el_ms     (q_ms),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  // back, part two: blanking rules and one character per cycle while out_tready is high
  stfmt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .char_code (char_code),
    .position  (position),
    .last      (out_tlast)
  );

  assign out_tdata = {6'b000000, position, char_code};

endmodule

FILE: tb/sv/stopwatch_time_formatter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_time_formatter_core_test
// Self-checking bench for the elapsed-time display formatter. A directed table
// covers the extremes, hour blanking, minute tens, the blinking colon and
// counter wrap. Random timestamp pairs follow. Every input transaction queues
// its fourteen display characters, and each output transaction is compared
// field by field against the oldest queued character.
// ----------------------------------------------------------------------------
module stopwatch_time_formatter_core_test;

  localparam int unsigned NUM_CHARS      = 14;
  localparam int unsigned RANDOM_PAIRS   = 100;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MS_PER_HOUR    = 3600000;

  // fourteen ascii characters, leftmost in the top byte; all zero means predict
  typedef logic [8*NUM_CHARS-1:0] disp_text_t;

  typedef struct packed {
    logic [stfmt_pkg::MS_W-1:0] start_ms;
    logic [stfmt_pkg::MS_W-1:0] stop_ms;
    disp_text_t                 text;
  } pair_row_t;

  // one display character as it leaves the block
  typedef struct packed {
    logic [stfmt_pkg::CHAR_W-1:0] code;
    logic [stfmt_pkg::POS_W-1:0]  pos;
    logic                         last;
  } disp_char_t;

  // directed pairs: the text is typed in where it is obvious, else predicted
  localparam int unsigned NUM_DIRECTED = 20;
  localparam pair_row_t DIRECTED_PAIRS [NUM_DIRECTED] = '{
    '{32'd0,          32'd0,          "      0:00.000"},  // nothing elapsed
    '{32'd0,          32'hFFFF_FFFF,  "1193:02:47.295"},  // longest interval
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  "      0:00.000"},  // all ones on both
    '{32'hFFFF_FFFF,  32'd0,          "      0:00.001"},  // counter wrap by one
    '{32'hFFFF_FC18,  32'd1000,       "      0:02.000"},  // wrap across zero
    '{32'd1000,       32'd3601000,    "   1:00:00.000"},  // one hour exactly
    '{32'd100,        32'd3661334,    "   1:01:01.234"},  // minute tens shown
    '{32'd0,          32'd36000000,   "  10:00:00.000"},  // two hour digits
    '{32'd0,          32'd360000000,  " 100:00:00.000"},  // three hour digits
    '{32'd0,          32'd3600000000, "1000:00:00.000"},  // four hour digits
    '{32'd0,          32'd3610800000, "1003:00:00.000"},  // inner hour zeros
    '{32'd0,          32'd499,        "      0:00.499"},  // colon still on
    '{32'd0,          32'd500,        "      0 00.500"},  // colon blinks off
    '{32'd0,          32'd599999,     "      9 59.999"},  // single minute digit
    '{32'd0,          32'd600000,     "     10:00.000"},  // first minute tens
    '{32'd0,          32'd3599999,    "     59 59.999"},  // just under an hour
    '{32'h1234_5678,  32'h9ABC_DEF0,  '0},
    '{32'hAAAA_AAAA,  32'h5555_5555,  '0},
    '{32'h5555_5555,  32'hAAAA_AAAA,  '0},
    '{32'h8000_0000,  32'h7FFF_FFFF,  '0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // start_ms[31:0], end_ms[63:32]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // char_code[5:0], position[9:6], zero pad
  logic        out_tlast;

  disp_text_t  row_text;        // typed text of the pair now on the input
  bit          idle_on;         // random gaps and stalls allowed
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  disp_char_t  pending_chars[$];  // characters still owed by the block

  stopwatch_time_formatter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [stfmt_pkg::CHAR_W-1:0] ascii_digit(input int unsigned d);
    logic [stfmt_pkg::CHAR_W-1:0] w;
    w = d[stfmt_pkg::CHAR_W-1:0];
    return stfmt_pkg::CH_ZERO + w;
  endfunction

  // queue one character at display position idx
  function automatic void owe_char(input int unsigned idx,
                                   input logic [stfmt_pkg::CHAR_W-1:0] code);
    disp_char_t c;
    c.code = code;
    c.pos  = idx[stfmt_pkg::POS_W-1:0];
    c.last = (c.pos == stfmt_pkg::POS_LAST);
    pending_chars.push_back(c);
  endfunction

  // display of one elapsed time, 'HHHH:MM:SS.mmm'
  function automatic void predict_display(input logic [stfmt_pkg::MS_W-1:0] elapsed);
    int unsigned                  secs_total, msec, secs, mins, hours, msh, mint;
    int unsigned                  hdig[4];
    logic [stfmt_pkg::CHAR_W-1:0] txt[NUM_CHARS];
    bit                           lead;
    int                           i;
    secs_total = elapsed / 1000;
    msec       = elapsed % 1000;
    secs       = secs_total % 60;
    mins       = (secs_total / 60) % 60;
    hours      = secs_total / 3600;
    msh        = msec / 100;
    mint       = mins / 10;
    hdig[0]    = (hours / 1000) % 10;
    hdig[1]    = (hours / 100) % 10;
    hdig[2]    = (hours / 10) % 10;
    hdig[3]    = hours % 10;
    if (hours != 0) begin
      // an upper hour zero is blank only while every higher digit is zero
      lead = 1'b0;
      for (i = 0; i < 3; i++) begin
        if (hdig[i] != 0) lead = 1'b1;
        txt[i] = lead ? ascii_digit(hdig[i]) : stfmt_pkg::CH_SPACE;
      end
      txt[stfmt_pkg::POS_H0]   = ascii_digit(hdig[3]);
      txt[stfmt_pkg::POS_HCOL] = stfmt_pkg::CH_COLON;
    end else begin
      for (i = 0; i < 5; i++) txt[i] = stfmt_pkg::CH_SPACE;
    end
    txt[stfmt_pkg::POS_MT]   = (mint != 0 || hours != 0) ? ascii_digit(mint)
                                                         : stfmt_pkg::CH_SPACE;
    txt[stfmt_pkg::POS_MU]   = ascii_digit(mins % 10);
    // colon off in the second half
    txt[stfmt_pkg::POS_MCOL] = (msh > 4) ? stfmt_pkg::CH_SPACE : stfmt_pkg::CH_COLON;
    txt[stfmt_pkg::POS_ST]   = ascii_digit(secs / 10);
    txt[stfmt_pkg::POS_SU]   = ascii_digit(secs % 10);
    txt[stfmt_pkg::POS_DOT]  = stfmt_pkg::CH_PERIOD;
    txt[stfmt_pkg::POS_MSH]  = ascii_digit(msh);
    txt[stfmt_pkg::POS_MST]  = ascii_digit((msec / 10) % 10);
    txt[stfmt_pkg::POS_MSU]  = ascii_digit(msec % 10);
    for (i = 0; i < NUM_CHARS; i++) owe_char(i, txt[i]);
  endfunction

  function automatic void compare_char(input disp_char_t got);
    disp_char_t want;
    if (pending_chars.size() == 0) begin
      $error("character with nothing owed: code %0d pos %0d last %0d",
             got.code, got.pos, got.last);
      fail_count++;
    end else begin
      want = pending_chars.pop_front();
      if (got.code !== want.code) begin
        $error("char_code: expected %0d, got %0d", want.code, got.code);
        fail_count++;
      end
      if (got.pos !== want.pos) begin
        $error("position: expected %0d, got %0d", want.pos, got.pos);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count++;
      end
    end
  endfunction

  // scoreboard: queue the display for each accepted pair, check each character
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (row_text != '0) begin
          for (int i = 0; i < NUM_CHARS; i++)
            owe_char(i, row_text[8*(NUM_CHARS-1-i) +: stfmt_pkg::CHAR_W]);
        end else begin
          predict_display(in_tdata[63:32] - in_tdata[31:0]);
        end
      end
      if (out_tvalid && out_tready)
        compare_char('{out_tdata[5:0], out_tdata[9:6], out_tlast});
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: ready with random stall bursts while idling is on
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // one pair on the input, held until accepted; valid stays up for the next
  task automatic send_pair(input logic [stfmt_pkg::MS_W-1:0] start_ms,
                           input logic [stfmt_pkg::MS_W-1:0] stop_ms,
                           input disp_text_t text);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {stop_ms, start_ms};
    row_text  = text;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender holds off until every owed character has come out
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  // random elapsed time, weighted toward boundaries and hour-scale values
  function automatic logic [stfmt_pkg::MS_W-1:0] pick_elapsed();
    logic [63:0] span;
    int unsigned tail_ms;
    case ($urandom_range(0, 5))
      0: span = 64'($urandom_range(0, 59999));
      1: span = 64'($urandom_range(0, MS_PER_HOUR - 1));
      2: span = 64'($urandom());
      3: span = 64'($urandom_range(1, 1193)) * 64'(MS_PER_HOUR)
              + 64'($urandom_range(0, MS_PER_HOUR - 1));
      4: span = 64'(32'hFFFF_FFFF - $urandom_range(0, 200000));
      default: begin
        case ($urandom_range(0, 3))
          0: tail_ms = 0;
          1: tail_ms = 499;
          2: tail_ms = 500;
          default: tail_ms = 999;
        endcase
        span = 64'($urandom_range(0, 1193)) * 64'(MS_PER_HOUR)
             + 64'($urandom_range(0, 59) * 60000)
             + 64'(($urandom_range(0, 1) != 0) ? 59000 : 0) + 64'(tail_ms);
      end
    endcase
    return span[stfmt_pkg::MS_W-1:0];
  endfunction

  // main sequence
  initial begin
    logic [stfmt_pkg::MS_W-1:0] start_ms;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    row_text   = '0;
    idle_on    = 1'b1;
    fail_count = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < NUM_DIRECTED; k++)
      send_pair(DIRECTED_PAIRS[k].start_ms, DIRECTED_PAIRS[k].stop_ms,
                DIRECTED_PAIRS[k].text);
    wait_drained();

    for (int k = 0; k < RANDOM_PAIRS; k++) begin
      if (k == 30) wait_drained();
      // a stretch without gaps mid-run, then none at all toward the end
      if (k == 45) idle_on = 1'b0;
      if (k == 55) idle_on = 1'b1;
      if (k == 80) idle_on = 1'b0;
      start_ms = $urandom();
      send_pair(start_ms, start_ms + pick_elapsed(), '0);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/stfmt_pkg.sv
design/stfmt_front.sv
design/stfmt_queue.sv
design/stfmt_conv.sv
design/stfmt_emit.sv
design/stopwatch_time_formatter_core.sv
tb/sv/stopwatch_time_formatter_core_test.sv
